>>> hdl/rtcc_pkg.sv
// Package for the real-time clock calendar: calendar and rollover types,
// calendar limits, action codes and the month length function.
// No dependencies; used by rtcc_step and rtc_calendar_counter.
`timescale 1ns / 1ps

package rtcc_pkg;

	// Year the calendar starts in after reset (two-digit).
	localparam logic [6:0] FIRST_YEAR = 7'd6;

	// Calendar limits.
	localparam logic [6:0] SEC_PER_MIN  = 7'd60;
	localparam logic [6:0] MIN_PER_HOUR = 7'd60;
	localparam logic [5:0] HOUR_PER_DAY = 6'd24;
	localparam logic [4:0] MONTH_COUNT  = 5'd13;
	localparam logic [3:0] MONTH_MAX    = 4'd12;
	localparam logic [6:0] YEAR_MAX     = 7'd99;
	localparam logic [7:0] RAW_YEAR_MAX = 8'd99;
	localparam logic [7:0] RAW_YEAR_CLR = 8'hFF;
	localparam logic [7:0] RAW_HOUR_MAX = 8'd23;
	localparam logic [7:0] RAW_MS_MAX   = 8'd59;
	localparam logic [7:0] RAW_MON_MAX  = 8'd12;

	// Month numbers with special lengths.
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_APR = 4'd4;
	localparam logic [3:0] MON_JUN = 4'd6;
	localparam logic [3:0] MON_SEP = 4'd9;
	localparam logic [3:0] MON_NOV = 4'd11;

	// Action codes carried in tuser.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} calendar_t;

	typedef struct packed {
		logic year_rolled;
		logic month_rolled;
		logic day_rolled;
		logic hour_rolled;
		logic minute_rolled;
	} rollover_t;

	typedef struct packed {
		logic [7:0] second;
		logic [7:0] minute;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] year;
	} set_fields_t;

	// Days in a month; leap marks a year divisible by four.
	function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month) inside
			MON_FEB:                            len = leap ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
			default:                            len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> hdl/rtcc_step.sv
// Next-state logic of the calendar: one tick with cascaded carries, or a
// clamped load of all fields. Purely combinational. Depends on rtcc_pkg.
`timescale 1ns / 1ps

module rtcc_step import rtcc_pkg::*; (
	input  logic        action,
	input  set_fields_t set_in,
	input  calendar_t   cal,
	output calendar_t   cal_next,
	output rollover_t   roll
);

	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [5:0] day_inc;
	logic [4:0] mon_inc;
	logic [7:0] y_c;
	logic [7:0] mo_c;
	logic [7:0] d_c;
	logic [4:0] set_len;

	assign sec_inc  = {1'b0, cal.second} + 7'd1;
	assign min_inc  = {1'b0, cal.minute} + 7'd1;
	assign hour_inc = {1'b0, cal.hour} + 6'd1;
	assign day_inc  = {1'b0, cal.day} + 6'd1;
	assign mon_inc  = {1'b0, cal.month} + 5'd1;

	// Clamping of the raw set fields; the day limit uses the clamped month and year.
	always_comb begin
		y_c = set_in.year;
		if (y_c == RAW_YEAR_CLR) y_c = '0;
		if (y_c > RAW_YEAR_MAX) y_c = RAW_YEAR_MAX;
		mo_c = set_in.month;
		if (mo_c == 8'd0) mo_c = 8'd1;
		if (mo_c > RAW_MON_MAX) mo_c = RAW_MON_MAX;
		set_len = month_len(mo_c[3:0], y_c[1:0] == 2'b00);
		d_c = set_in.day;
		if (d_c == 8'd0) d_c = 8'd1;
		if (d_c > {3'd0, set_len}) d_c = {3'd0, set_len};
	end

	// Tick cascade or load.
	always_comb begin
		cal_next = cal;
		roll     = '0;
		if (action == ACT_SET) begin
			cal_next.year   = y_c[6:0];
			cal_next.month  = mo_c[3:0];
			cal_next.day    = d_c[4:0];
			cal_next.hour   = (set_in.hour > RAW_HOUR_MAX) ? 5'd0 : set_in.hour[4:0];
			cal_next.minute = (set_in.minute > RAW_MS_MAX) ? 6'd0 : set_in.minute[5:0];
			cal_next.second = (set_in.second > RAW_MS_MAX) ? 6'd0 : set_in.second[5:0];
		end else begin
			cal_next.second = sec_inc[5:0];
			if (sec_inc >= SEC_PER_MIN) begin
				cal_next.second    = '0;
				cal_next.minute    = min_inc[5:0];
				roll.minute_rolled = 1'b1;
				if (min_inc >= MIN_PER_HOUR) begin
					cal_next.minute  = '0;
					cal_next.hour    = hour_inc[4:0];
					roll.hour_rolled = 1'b1;
					if (hour_inc >= HOUR_PER_DAY) begin
						cal_next.hour   = '0;
						cal_next.day    = day_inc[4:0];
						roll.day_rolled = 1'b1;
						if (day_inc > {1'b0, month_len(cal.month, cal.year[1:0] == 2'b00)}) begin
							cal_next.day      = 5'd1;
							cal_next.month    = mon_inc[3:0];
							roll.month_rolled = 1'b1;
							if (mon_inc >= MONTH_COUNT) begin
								cal_next.month   = 4'd1;
								roll.year_rolled = 1'b1;
								cal_next.year    = (cal.year >= YEAR_MAX) ? 7'd0 :
									cal.year + 7'd1;
							end
						end
					end
				end
			end
		end
	end

endmodule

>>> hdl/rtc_calendar_counter.sv
// Top level of the real-time clock calendar: input register, calendar state
// and result register around the rtcc_step logic. Depends on rtcc_pkg, rtcc_step.
//
// Channel  Dir  Data                                    Side band
// s_axis   in   set fields (48 bits)                     tuser: action
// m_axis   out  calendar after the step + rollover flags none
//
// One item per cycle sustained while m_axis does not stall; each item passes
// the input register and then the result register. The calendar step is a single
// combinational pass from the input register to the calendar register.
// Reset sets 00:00:00 on day 1, month 1 of the first year, both stages empty.
// A stall on m_axis holds the result and fills the input register, then
// lowers s_axis_tready.
`timescale 1ns / 1ps

module rtc_calendar_counter import rtcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// set_year, set_month, set_day, set_hour, set_minute, set_second
	input  logic [47:0] s_axis_tdata,
	// action
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// year_now, month_now, day_now, hour_now, minute_now, second_now,
	// minute_rolled, hour_rolled, day_rolled, month_rolled, year_rolled, 2 zero bits
	output logic [39:0] m_axis_tdata
);

	logic        valid_s1;
	logic        action_s1;
	set_fields_t set_s1;
	calendar_t   cal_q;
	calendar_t   cal_next;
	rollover_t   roll_next;
	rollover_t   roll_s2;
	logic        valid_s2;
	logic        advance;

	// The item moves on when the result register is empty or being emptied.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1     <= s_axis_tuser;
			set_s1.year   <= s_axis_tdata[7:0];
			set_s1.month  <= s_axis_tdata[15:8];
			set_s1.day    <= s_axis_tdata[23:16];
			set_s1.hour   <= s_axis_tdata[31:24];
			set_s1.minute <= s_axis_tdata[39:32];
			set_s1.second <= s_axis_tdata[47:40];
		end
	end

	rtcc_step u_step (
		.action   (action_s1),
		.set_in   (set_s1),
		.cal      (cal_q),
		.cal_next (cal_next),
		.roll     (roll_next)
	);

	// Calendar state doubles as the result payload: it only changes when a
	// new result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= '{second: 6'd0, minute: 6'd0, hour: 5'd0, day: 5'd1,
				month: 4'd1, year: FIRST_YEAR};
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				cal_q <= cal_next;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			roll_s2 <= roll_next;
		end
	end

	// Result packing.
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, roll_s2.year_rolled, roll_s2.month_rolled,
		roll_s2.day_rolled, roll_s2.hour_rolled, roll_s2.minute_rolled,
		cal_q.second, cal_q.minute, cal_q.hour, cal_q.day, cal_q.month, cal_q.year};

	// The calendar never leaves its legal range.
	a_cal_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_q.second < 6'd60 && cal_q.minute < 6'd60 && cal_q.hour < 5'd24 &&
		cal_q.month >= 4'd1 && cal_q.month <= MONTH_MAX && cal_q.year <= YEAR_MAX &&
		cal_q.day >= 5'd1 && cal_q.day <= month_len(cal_q.month, cal_q.year[1:0] == 2'b00))
		else $error("calendar state out of range");

	// An hour rollover implies a minute rollover and a zero minute; a minute rollover, a zero second.
	a_roll_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && roll_s2.hour_rolled |-> roll_s2.minute_rolled && cal_q.minute == 6'd0)
		else $error("hour rollover without minute rollover");

	a_roll_min: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && roll_s2.minute_rolled |-> cal_q.second == 6'd0)
		else $error("minute rollover with nonzero second");

	// The calendar holds while no item advances.
	a_cal_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cal_q))
		else $error("calendar changed without an item");

endmodule
